@@ design/dspm_pkg.sv @@
package dspm_pkg;

   localparam int MAX_ELEMENTS_DEFAULT = 32;

   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_DOT  = 8'h2E;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_TEXT   = 2'd1,
      CMD_END    = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

endpackage

@@ design/dspm_closure.sv @@
module dspm_closure
   import dspm_pkg::*;
#(
   parameter int N_ELEM = MAX_ELEMENTS_DEFAULT
) (
   input  logic [N_ELEM:0]   pos_set,
   input  logic [N_ELEM-1:0] star_flags,
   output logic [N_ELEM:0]   pos_closed
);

   localparam int NPOS = N_ELEM + 1;
   localparam int LV   = $clog2(NPOS);

   // parallel prefix: a position spreads forward across a run of starred elements
   logic [NPOS-1:0] s_lv [0:LV];
   logic [NPOS-1:0] l_lv [0:LV];

   assign s_lv[0] = pos_set;
   assign l_lv[0] = {star_flags, 1'b0};

   genvar k, j;
   generate
      for (k = 0; k < LV; k++) begin : g_level
         for (j = 0; j < NPOS; j++) begin : g_pos
            if (j >= (1 << k)) begin : g_span
               assign s_lv[k+1][j] = s_lv[k][j] | (l_lv[k][j] & s_lv[k][j-(1<<k)]);
               assign l_lv[k+1][j] = l_lv[k][j] & l_lv[k][j-(1<<k)];
            end else begin : g_head
               assign s_lv[k+1][j] = s_lv[k][j];
               assign l_lv[k+1][j] = 1'b0;
            end
         end
      end
   endgenerate

   assign pos_closed = s_lv[LV];

endmodule

@@ design/dot_star_pattern_matcher.sv @@
// an accepted end-of-text request passes the request register, then the result register, on its way to rsp_valid
// throughput: one request per cycle, any mix of pattern, text, end and clear;
// an end request waits in the request register only while a result is still held
// the per-byte nfa step (prefix closure plus element compare) sits between
// the request register and the state / result registers
// reset (synchronous, active high) empties the pattern, clears overflow,
// arms the start position and drops any queued request and result
module dot_star_pattern_matcher
   import dspm_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_overflow
);

   localparam int NPOS = MAX_ELEMENTS + 1;
   localparam int CW   = $clog2(NPOS);
   localparam int IW   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

   // request register
   logic      in_valid_ff, in_valid_in;
   cmd_type   in_cmd_ff;
   logic [7:0] in_ch_ff;

   // pattern and nfa state
   logic [7:0]              elem_byte_ff [0:MAX_ELEMENTS-1];
   logic [MAX_ELEMENTS-1:0] starred_ff, starred_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [NPOS-1:0]         active_ff, active_in;
   logic                    ovf_ff, ovf_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_matched_ff, rsp_overflow_ff;

   logic advance;
   logic fire_end;
   logic req_fire;

   // an end request waits only if the result slot is held
   assign advance  = in_valid_ff && ((in_cmd_ff != CMD_END) || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire = req_valid && req_ready;
   assign fire_end = advance && (in_cmd_ff == CMD_END);

   // closure of the stored active set
   logic [NPOS-1:0] closed;

   dspm_closure #(
      .N_ELEM (MAX_ELEMENTS)
   ) u_closure (
      .pos_set    (active_ff),
      .star_flags (starred_ff),
      .pos_closed (closed)
   );

   // element i is live when i < count; position j is reachable when j <= count
   logic [MAX_ELEMENTS-1:0] live;
   logic [NPOS-1:0]         upto_count;
   logic [MAX_ELEMENTS-1:0] hit;

   genvar i;
   generate
      for (i = 0; i < MAX_ELEMENTS; i++) begin : g_elem
         assign live[i] = CW'(i) < count_ff;
         assign hit[i]  = closed[i] && live[i] &&
                          ((elem_byte_ff[i] == CH_DOT) || (elem_byte_ff[i] == in_ch_ff));
      end
      for (i = 0; i < NPOS; i++) begin : g_pos
         assign upto_count[i] = CW'(i) <= count_ff;
      end
   endgenerate

   // starred element loops on itself, plain element moves one position on
   logic [NPOS-1:0] text_next;
   assign text_next = {1'b0, hit & starred_ff} | {hit & ~starred_ff, 1'b0};

   // append decode
   logic [CW-1:0] count_m1;
   logic [IW-1:0] last_idx;
   logic [IW-1:0] wr_idx;
   logic          star_hit;
   logic          store_full;
   logic          elem_wr;

   assign count_m1   = count_ff - CW'(1);
   assign last_idx   = count_m1[IW-1:0];
   assign wr_idx     = count_ff[IW-1:0];
   assign store_full = (count_ff == CW'(MAX_ELEMENTS));
   // a star with nothing to star is kept as a literal
   assign star_hit   = (in_ch_ff == CH_STAR) && (count_ff != '0) && !starred_ff[last_idx];
   assign elem_wr    = advance && (in_cmd_ff == CMD_APPEND) && !star_hit && !store_full;

   always_comb begin
      starred_in = starred_ff;
      count_in   = count_ff;
      active_in  = active_ff;
      ovf_in     = ovf_ff;
      if (advance) begin
         unique case (in_cmd_ff)
            CMD_APPEND: begin
               if (star_hit) begin
                  starred_in[last_idx] = 1'b1;
               end else if (!store_full) begin
                  starred_in[wr_idx] = 1'b0;
                  count_in           = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               active_in = NPOS'(1);
            end
            CMD_TEXT: begin
               active_in = text_next;
            end
            CMD_END: begin
               active_in = NPOS'(1);
            end
            CMD_CLEAR: begin
               starred_in = '0;
               count_in   = '0;
               ovf_in     = 1'b0;
               active_in  = NPOS'(1);
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   assign rsp_valid_in = fire_end || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         starred_ff   <= '0;
         count_ff     <= '0;
         active_ff    <= NPOS'(1);
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         starred_ff   <= starred_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff <= cmd_type'(req_cmd);
         in_ch_ff  <= req_ch;
      end
      if (elem_wr) begin
         elem_byte_ff[wr_idx] <= in_ch_ff;
      end
      if (fire_end) begin
         // end position reachable after closure, unless the pattern overflowed
         rsp_matched_ff  <= closed[count_ff] && !ovf_ff;
         rsp_overflow_ff <= ovf_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_matched  = rsp_matched_ff;
   assign rsp_overflow = rsp_overflow_ff;

`ifndef SYNTHESIS
   // an overflowed pattern never reports a match
   a_ovf_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_matched && rsp_overflow))
      else $error("match reported with overflow");

   // clear empties the pattern store
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_cmd_ff == CMD_CLEAR)) |=> ((count_ff == '0) && !ovf_ff))
      else $error("clear did not empty pattern");

   // no live position beyond the end of the pattern
   a_active_bounded: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~upto_count) == '0)
      else $error("active position beyond pattern end");

   // an end request produces a result in the next cycle
   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire_end |=> rsp_valid)
      else $error("end request without result");
`endif

endmodule

@@ dv/tb_dot_star_pattern_matcher.sv @@
`timescale 1ns / 1ps

module tb_dot_star_pattern_matcher;
   import dspm_pkg::*;

   // element store size of the block as built here
   localparam int NUM_ELEM = MAX_ELEMENTS_DEFAULT;
   localparam logic [NUM_ELEM:0] START_POS = (NUM_ELEM + 1)'(1);

   // run limits, in clock cycles, and the number of random requests
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_LIMIT = 5000;
   localparam int HOLD_CYCLES = 150;
   localparam int TAIL_CYCLES = 8;
   localparam int RANDOM_REQUESTS = 410;

   typedef struct packed {
      logic matched;
      logic overflow;
   } match_result_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_cmd;
   logic [7:0] req_ch;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_matched;
   logic       rsp_overflow;

   dot_star_pattern_matcher u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_ch      (req_ch),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_matched (rsp_matched),
      .rsp_overflow(rsp_overflow)
   );

   // ------------------------------------------------------------------
   // matcher state as the testbench tracks it
   // ------------------------------------------------------------------
   logic [7:0]        pat_bytes [NUM_ELEM];
   bit                pat_star  [NUM_ELEM];
   int                pat_len;
   logic [NUM_ELEM:0] live_pos;   // kept without closure
   bit                pat_ovf;

   match_result_type expected_matches[$];

   int  mismatch_count;
   int  requests_sent;
   int  cycle_count;
   int  burst_left;
   bit  sender_bursty;   // sender inserts gaps between bursts
   int  stall_pct;       // chance that the receiver picks a stalled run
   bit  hold_request;    // asks the receiver for one long hold-off

   // positions reachable once starred elements may be skipped
   function automatic logic [NUM_ELEM:0] closed_set(logic [NUM_ELEM:0] s);
      for (int i = 0; i < pat_len; i++) begin
         if (s[i] && pat_star[i]) s[i+1] = 1'b1;
      end
      return s;
   endfunction

   // advance the tracked state by one accepted request
   function automatic void apply_request(cmd_type cmd, logic [7:0] ch);
      logic [NUM_ELEM:0] cur;
      logic [NUM_ELEM:0] nxt;
      match_result_type  want;
      case (cmd)
         CMD_APPEND: begin
            // a star with nothing left to star becomes a literal element
            if (ch == CH_STAR && pat_len > 0 && !pat_star[pat_len-1]) begin
               pat_star[pat_len-1] = 1'b1;
            end else if (pat_len < NUM_ELEM) begin
               pat_bytes[pat_len] = ch;
               pat_star[pat_len]  = 1'b0;
               pat_len++;
            end else begin
               pat_ovf = 1'b1;
            end
            live_pos = START_POS;
         end
         CMD_TEXT: begin
            cur = closed_set(live_pos);
            nxt = '0;
            for (int i = 0; i < pat_len; i++) begin
               if (cur[i] && (pat_bytes[i] == CH_DOT || pat_bytes[i] == ch)) begin
                  if (pat_star[i]) nxt[i] = 1'b1;
                  else nxt[i+1] = 1'b1;
               end
            end
            live_pos = nxt;
         end
         CMD_END: begin
            cur = closed_set(live_pos);
            want.matched  = cur[pat_len] && !pat_ovf;
            want.overflow = pat_ovf;
            expected_matches.push_back(want);
            live_pos = START_POS;
         end
         default: begin
            foreach (pat_star[i]) pat_star[i] = 1'b0;
            pat_len  = 0;
            pat_ovf  = 1'b0;
            live_pos = START_POS;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // clock, cycle limit
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // receiver: runs of ready and stall of random length, plus one long
   // hold-off on demand, counted here in its own cycles
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int run_left;
      int hold_left;
      bit run_ready;
      rsp_ready = 1'b0;
      run_left  = 0;
      hold_left = 0;
      run_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               run_ready = ($urandom_range(99) >= stall_pct);
               run_left  = $urandom_range(1, 8);
            end
            run_left--;
            rsp_ready <= run_ready;
         end
      end
   end

   // ------------------------------------------------------------------
   // result checker: oldest expectation against each accepted result
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      match_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_matches.size() == 0) begin
            $display("%0t: unexpected result, matched %0b overflow %0b",
                     $time, rsp_matched, rsp_overflow);
            mismatch_count++;
         end else begin
            want = expected_matches.pop_front();
            if (rsp_matched !== want.matched) begin
               $display("%0t: matched mismatch, expected %0b actual %0b",
                        $time, want.matched, rsp_matched);
               mismatch_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $display("%0t: overflow mismatch, expected %0b actual %0b",
                        $time, want.overflow, rsp_overflow);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------

   // offer one request, hold it until accepted, then track it
   task automatic send_request(cmd_type cmd, logic [7:0] ch);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_ch    <= ch;
      do @(posedge clock); while (req_ready !== 1'b1);
      apply_request(cmd, ch);
      requests_sent++;
      // bursts of random length, with random gaps between them when the sender is bursty
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         if (sender_bursty) begin
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic send_pattern(string s);
      for (int i = 0; i < s.len(); i++) send_request(CMD_APPEND, s[i]);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_request(CMD_TEXT, s[i]);
   endtask

   // drop valid and wait for every expected result, up to the drain limit
   task automatic wait_results_drained();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_matches.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // text bytes mostly from a small alphabet so matches happen
   function automatic logic [7:0] pick_text_byte();
      case ($urandom_range(7))
         0:       return 8'($urandom_range(255));
         1, 2:    return "a";
         3, 4:    return "b";
         default: return "c";
      endcase
   endfunction

   function automatic logic [7:0] pick_pattern_byte();
      case ($urandom_range(9))
         0:       return 8'($urandom_range(255));
         1, 2:    return CH_STAR;
         3:       return CH_DOT;
         4, 5:    return "a";
         6, 7:    return "b";
         default: return "c";
      endcase
   endfunction

   // ------------------------------------------------------------------
   // directed tests
   // ------------------------------------------------------------------

   // empty pattern: only the empty text matches
   task automatic test_empty_pattern();
      send_request(CMD_END, 8'hFF);       // end after no text
      send_text("a");
      send_request(CMD_END, 8'h00);
   endtask

   // literals and the any-byte element
   task automatic test_literal_and_dot();
      send_request(CMD_CLEAR, 8'h55);
      send_pattern("a.");
      send_request(CMD_END, 8'h00);       // too short
      send_text("az");
      send_request(CMD_END, 8'h00);
      send_request(CMD_TEXT, 8'h80);
      send_request(CMD_END, 8'h00);
   endtask

   // leading star and a star after a starred element are literal stars
   task automatic test_literal_stars();
      send_request(CMD_CLEAR, 8'h00);
      send_pattern("*b**");
      send_text("*bb*");
      send_request(CMD_END, 8'h00);
      send_text("**");
      send_request(CMD_END, 8'h00);
      send_text("*");
      send_request(CMD_END, 8'h00);
   endtask

   // pattern append or clear in the middle of a text rearms the nfa
   task automatic test_edit_during_text();
      send_request(CMD_CLEAR, 8'h00);
      send_pattern("x*");
      send_text("x");
      send_request(CMD_APPEND, "y");
      send_text("y");
      send_request(CMD_END, 8'h00);
      send_text("q");
      send_request(CMD_CLEAR, 8'hAA);
      send_request(CMD_END, 8'h00);       // empty pattern, rearmed
   endtask

   // a zero byte is just another literal
   task automatic test_zero_byte();
      send_request(CMD_APPEND, 8'h00);
      send_request(CMD_TEXT, 8'h00);
      send_request(CMD_END, 8'h00);
      send_request(CMD_TEXT, 8'h01);
      send_request(CMD_END, 8'h00);
   endtask

   // store exactly full, then one element too many
   task automatic test_store_full();
      send_request(CMD_CLEAR, 8'h00);
      repeat (NUM_ELEM) send_request(CMD_APPEND, CH_DOT);
      repeat (NUM_ELEM) send_request(CMD_TEXT, pick_text_byte());
      send_request(CMD_END, 8'h00);
      send_request(CMD_APPEND, CH_STAR);  // still stars the last element
      send_request(CMD_END, 8'h00);
      send_request(CMD_APPEND, "q");      // dropped, overflow set
      send_request(CMD_END, 8'h00);
      repeat (NUM_ELEM) send_request(CMD_TEXT, "a");
      send_request(CMD_END, 8'h00);
      send_request(CMD_CLEAR, 8'h00);
      send_request(CMD_END, 8'h00);
   endtask

   // long receiver hold-off while the sender keeps sending text and end requests
   task automatic test_backpressure();
      sender_bursty = 1'b0;
      stall_pct     = 0;
      send_request(CMD_CLEAR, 8'h00);
      send_pattern("a*");
      hold_request = 1'b1;
      repeat (20) begin
         send_request(CMD_TEXT, "a");
         send_request(CMD_END, 8'h00);
      end
      wait_results_drained();
   endtask

   // ------------------------------------------------------------------
   // random sessions: clear, pattern, several texts each closed by an end
   // ------------------------------------------------------------------
   task automatic test_random_sessions(int target);
      int n_pat;
      int reps;
      logic [7:0] b;
      while (requests_sent < target) begin
         // move the pacing around from session to session
         if ($urandom_range(4) == 0) begin
            sender_bursty = 1'($urandom_range(1));
            case ($urandom_range(2))
               0:       stall_pct = 0;
               1:       stall_pct = 30;
               default: stall_pct = 70;
            endcase
         end
         send_request(CMD_CLEAR, 8'($urandom_range(255)));
         n_pat = ($urandom_range(15) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
         repeat (n_pat) send_request(CMD_APPEND, pick_pattern_byte());
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(3) != 0) begin
               // text built from the pattern, then sometimes spoiled
               for (int i = 0; i < pat_len; i++) begin
                  reps = pat_star[i] ? $urandom_range(0, 3) : 1;
                  repeat (reps) begin
                     b = (pat_bytes[i] == CH_DOT) ? pick_text_byte() : pat_bytes[i];
                     send_request(CMD_TEXT, b);
                  end
               end
               if ($urandom_range(3) == 0) send_request(CMD_TEXT, pick_text_byte());
            end else begin
               repeat ($urandom_range(0, 8)) send_request(CMD_TEXT, pick_text_byte());
            end
            // noise: any command with any byte, pattern edits included
            if ($urandom_range(7) == 0) begin
               send_request(cmd_type'($urandom_range(3)), 8'($urandom_range(255)));
            end
            send_request(CMD_END, 8'($urandom_range(255)));
         end
         // now and then the sender waits for all results
         if ($urandom_range(9) == 0) wait_results_drained();
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cmd       = CMD_APPEND;
      req_ch        = 8'h00;
      hold_request  = 1'b0;
      sender_bursty = 1'b1;
      stall_pct     = 30;
      burst_left    = 1;
      mismatch_count = 0;
      requests_sent  = 0;
      cycle_count    = 0;
      foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
      foreach (pat_star[i]) pat_star[i] = 1'b0;
      pat_len  = 0;
      pat_ovf  = 1'b0;
      live_pos = START_POS;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_pattern();
      test_literal_and_dot();
      test_literal_stars();
      test_edit_during_text();
      test_zero_byte();
      wait_results_drained();   // sender pause with everything settled
      test_store_full();
      test_backpressure();
      test_random_sessions(requests_sent + RANDOM_REQUESTS);

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_matches.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_matches.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/dspm_pkg.sv
design/dspm_closure.sv
design/dot_star_pattern_matcher.sv
dv/tb_dot_star_pattern_matcher.sv
